// ===== hdl/pgcr_pkg.sv =====
// Shared types, constants and functions for the percent glyph column renderer.
// No dependencies; every other file of the block refers to this package.
package pgcr_pkg;

    localparam int GLYPH_WIDTH_DEF = 7;
    localparam int ROM_COLS        = 7;
    localparam int QUEUE_DEPTH     = 2;

    localparam int PERCENT_W = 8;
    localparam int PAGE_W    = 3;
    localparam int COLUMN_W  = 7;
    localparam int BYTES_W   = 24;
    localparam int SLOT_W    = 2;
    localparam int DIGIT_W   = 4;

    localparam logic [PAGE_W-1:0] TOP_PAGE_RESET = 3'd3;

    // Slot codes.
    localparam logic [SLOT_W-1:0] SLOT_HUNDREDS = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_TENS     = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_UNITS    = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_PERCENT  = 2'd3;

    // Font index of the percent sign.
    localparam logic [DIGIT_W-1:0] GLYPH_PERCENT = 4'd10;

    // Configuration register indexes.
    localparam logic REG_TOP_PAGE = 1'b0;

    // One classified value: where the readout starts and its three digits.
    typedef struct packed {
        logic [SLOT_W-1:0]             first_slot;
        logic [2:0][DIGIT_W-1:0]       digit;
    } t_desc;

    function automatic logic [COLUMN_W-1:0] slot_base(input logic [SLOT_W-1:0] slot);
        logic [COLUMN_W-1:0] base;
        unique case (slot)
            SLOT_HUNDREDS: base = 7'd23;
            SLOT_TENS:     base = 7'd44;
            SLOT_UNITS:    base = 7'd65;
            SLOT_PERCENT:  base = 7'd90;
            default:       base = 7'd0;
        endcase
        return base;
    endfunction

    // Seven-column font: digits 0 to 9 and the percent sign.
    function automatic logic [7:0] font_col(input logic [DIGIT_W-1:0] glyph,
                                            input logic [2:0] col);
        logic [6:0][7:0] g;
        logic [7:0]      v;
        unique case (glyph)
            4'd0:    g = {8'h00, 8'h7F, 8'h41, 8'h41, 8'h41, 8'h7F, 8'h00};
            4'd1:    g = {8'h00, 8'h00, 8'h40, 8'h7F, 8'h41, 8'h02, 8'h00};
            4'd2:    g = {8'h00, 8'h4F, 8'h49, 8'h49, 8'h49, 8'h79, 8'h00};
            4'd3:    g = {8'h00, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h49, 8'h00};
            4'd4:    g = {8'h00, 8'h7F, 8'h08, 8'h08, 8'h08, 8'h0F, 8'h00};
            4'd5:    g = {8'h00, 8'h79, 8'h49, 8'h49, 8'h49, 8'h4F, 8'h00};
            4'd6:    g = {8'h00, 8'h79, 8'h49, 8'h49, 8'h49, 8'h7F, 8'h00};
            4'd7:    g = {8'h00, 8'h03, 8'h0D, 8'h11, 8'h61, 8'h01, 8'h00};
            4'd8:    g = {8'h00, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h7F, 8'h00};
            4'd9:    g = {8'h00, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h4F, 8'h00};
            4'd10:   g = {8'h61, 8'h62, 8'h04, 8'h08, 8'h10, 8'h23, 8'h43};
            default: g = '0;
        endcase
        if (col < 3'(ROM_COLS)) begin
            v = g[col];
        end else begin
            v = 8'h00;
        end
        return v;
    endfunction

    // Each source bit fills three adjacent result bits.
    function automatic logic [BYTES_W-1:0] triple_column(input logic [7:0] src);
        logic [BYTES_W-1:0] acc;
        acc = '0;
        for (int b = 0; b < 8; b++) begin
            acc[3*b +: 3] = {3{src[b]}};
        end
        return acc;
    endfunction

endpackage

// ===== hdl/pgcr_if.sv =====
// Valid/ready channel interfaces for the value input and the column results.
// Depends on pgcr_pkg for field widths.
interface pgcr_in_if;
    logic                           valid;
    logic                           ready;
    logic [pgcr_pkg::PERCENT_W-1:0] percent;

    modport source (output valid, output percent, input ready);
    modport sink   (input valid, input percent, output ready);
endinterface

interface pgcr_out_if;
    logic                          valid;
    logic                          ready;
    logic [pgcr_pkg::SLOT_W-1:0]   glyph_slot;
    logic [pgcr_pkg::COLUMN_W-1:0] display_column;
    logic [pgcr_pkg::PAGE_W-1:0]   start_page;
    logic [pgcr_pkg::BYTES_W-1:0]  page_bytes;
    logic                          last_column;

    modport source (output valid, output glyph_slot, output display_column,
                    output start_page, output page_bytes, output last_column,
                    input ready);
    modport sink   (input valid, input glyph_slot, input display_column,
                    input start_page, input page_bytes, input last_column,
                    output ready);
endinterface

// ===== hdl/pgcr_front.sv =====
// Front end: accepts a value and splits it into digits and a first slot.
// Depends on pgcr_pkg and pgcr_in_if.
module pgcr_front (
    pgcr_in_if.sink          i_in,
    input  logic             i_q_full,
    output logic             o_push,
    output pgcr_pkg::t_desc  o_desc
);

    logic [7:0]  hund_sub;
    logic [1:0]  hund;
    logic [6:0]  rem_h;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;

    // Hundreds by comparison, tens by multiplying with 205/2048, which is
    // exact for remainders below one hundred.
    always_comb begin
        if (i_in.percent >= 8'd200) begin
            hund     = 2'd2;
            hund_sub = 8'd200;
        end else if (i_in.percent >= 8'd100) begin
            hund     = 2'd1;
            hund_sub = 8'd100;
        end else begin
            hund     = 2'd0;
            hund_sub = 8'd0;
        end
        rem_h = 7'(i_in.percent - hund_sub);
        prod  = 15'(rem_h) * 15'd205;
        tens  = prod[14:11];
        units = rem_h - 7'(tens) * 7'd10;
    end

    always_comb begin
        o_desc.digit[0] = 4'(hund);
        o_desc.digit[1] = tens;
        o_desc.digit[2] = units[3:0];
        if (hund == 2'd0 && tens == 4'd0) begin
            o_desc.first_slot = pgcr_pkg::SLOT_UNITS;
        end else if (hund == 2'd0) begin
            o_desc.first_slot = pgcr_pkg::SLOT_TENS;
        end else begin
            o_desc.first_slot = pgcr_pkg::SLOT_HUNDREDS;
        end
    end

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

endmodule

// ===== hdl/pgcr_queue.sv =====
// Short first-in first-out queue of classified values between front and back.
// Depends on pgcr_pkg for the entry type and depth.
module pgcr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pgcr_pkg::t_desc  i_desc,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output pgcr_pkg::t_desc  o_desc
);

    localparam int DEPTH = pgcr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pgcr_pkg::t_desc   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule

// ===== hdl/pgcr_back.sv =====
// Back end: steps through slots and font columns and registers one result a cycle
// when a value waits and the output is free. Depends on pgcr_pkg and pgcr_out_if.
module pgcr_back #(
    parameter int GLYPH_WIDTH = pgcr_pkg::GLYPH_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  pgcr_pkg::t_desc               i_desc,
    input  logic [pgcr_pkg::PAGE_W-1:0]   i_top_page,
    output logic                          o_pop,
    pgcr_out_if.source                    o_out
);

    localparam int NCOLS = (GLYPH_WIDTH > pgcr_pkg::ROM_COLS) ? pgcr_pkg::ROM_COLS
                                                               : GLYPH_WIDTH;
    localparam int COL_W = (NCOLS > 1) ? $clog2(NCOLS) : 1;

    logic                          r_busy, n_busy;
    logic [pgcr_pkg::SLOT_W-1:0]   r_slot, n_slot;
    logic [COL_W-1:0]              r_col, n_col;
    logic                          r_ovalid;

    logic [pgcr_pkg::SLOT_W-1:0]   cur_slot;
    logic [COL_W-1:0]              cur_col;
    logic [pgcr_pkg::DIGIT_W-1:0]  glyph;
    logic                          col_end, last, advance;

    logic [pgcr_pkg::SLOT_W-1:0]   r_glyph_slot;
    logic [pgcr_pkg::COLUMN_W-1:0] r_display_column;
    logic [pgcr_pkg::PAGE_W-1:0]   r_start_page;
    logic [pgcr_pkg::BYTES_W-1:0]  r_page_bytes;
    logic                          r_last_column;

    // A fresh value starts at its first slot and column zero.
    assign cur_slot = r_busy ? r_slot : i_desc.first_slot;
    assign cur_col  = r_busy ? r_col : '0;
    assign glyph    = (cur_slot == pgcr_pkg::SLOT_PERCENT) ? pgcr_pkg::GLYPH_PERCENT
                                                           : i_desc.digit[cur_slot];
    assign col_end  = (cur_col == COL_W'(NCOLS - 1));
    assign last     = col_end && (cur_slot == pgcr_pkg::SLOT_PERCENT);
    assign advance  = i_q_valid && (!r_ovalid || o_out.ready);
    assign o_pop    = advance && last;

    always_comb begin
        n_busy = r_busy;
        n_slot = r_slot;
        n_col  = r_col;
        if (advance) begin
            n_busy = !last;
            if (col_end) begin
                n_slot = cur_slot + 1'b1;
                n_col  = '0;
            end else begin
                n_slot = cur_slot;
                n_col  = cur_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_slot   <= '0;
            r_col    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_slot <= n_slot;
            r_col  <= n_col;
            if (advance) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_glyph_slot     <= cur_slot;
            r_display_column <= pgcr_pkg::slot_base(cur_slot)
                                + pgcr_pkg::COLUMN_W'(cur_col) * 7'd3;
            r_start_page     <= i_top_page;
            r_page_bytes     <= pgcr_pkg::triple_column(
                                    pgcr_pkg::font_col(glyph, 3'(cur_col)));
            r_last_column    <= last;
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.glyph_slot     = r_glyph_slot;
    assign o_out.display_column = r_display_column;
    assign o_out.start_page     = r_start_page;
    assign o_out.page_bytes     = r_page_bytes;
    assign o_out.last_column    = r_last_column;

endmodule

// ===== hdl/percent_glyph_column_renderer_top.sv =====
// Top level of the percent glyph column renderer: register port, front, queue, back.
// Depends on pgcr_pkg, pgcr_if, pgcr_front, pgcr_queue and pgcr_back.

// Each accepted 8-bit value becomes a readout of its decimal digits, leading
// zeros dropped, followed by a percent sign, sent one font column per result.
// A value below 10 yields two glyphs, below 100 three, otherwise four, so an
// item produces 2, 3 or 4 times min(GLYPH_WIDTH, 7) results: 14, 21 or 28 at
// the default width. The back end's slot and column sequencer issues one
// result per clock whenever a value is queued and the output register is free,
// so consecutive items follow with no gap. The front end takes a new value in
// the same cycle it is offered as long as the two-entry queue has room. The
// value being drawn keeps its queue entry until its last column is issued, so
// one further value may wait in the queue behind it. When the block is idle,
// the first result of a value is registered in the queue entry and then in
// the output register before it is presented. The top_page register sits at
// byte address 0 of the APB port and is copied into start_page of every
// result; writes complete in the access cycle and pready is always high.
module percent_glyph_column_renderer_top #(
    parameter int GLYPH_WIDTH = pgcr_pkg::GLYPH_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pgcr_in_if.sink     i_in,
    pgcr_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [pgcr_pkg::PAGE_W-1:0] r_top_page;
    logic                        cfg_write;

    logic                        q_push;
    logic                        q_full;
    logic                        q_valid;
    logic                        q_pop;
    pgcr_pkg::t_desc             front_desc;
    pgcr_pkg::t_desc             head_desc;

    // Register port. Bit 2 of the byte address selects the register; only
    // the top_page register exists, other addresses read as zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == pgcr_pkg::REG_TOP_PAGE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_page <= pgcr_pkg::TOP_PAGE_RESET;
        end else if (cfg_write) begin
            r_top_page <= pwdata[pgcr_pkg::PAGE_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == pgcr_pkg::REG_TOP_PAGE) begin
            prdata = {{(32 - pgcr_pkg::PAGE_W){1'b0}}, r_top_page};
        end else begin
            prdata = '0;
        end
    end

    // The front end classifies each request and hands it to the queue.
    pgcr_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_desc   (front_desc)
    );

    pgcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (front_desc),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_desc  (head_desc)
    );

    // The back end retires a queue entry with the percent sign's last column.
    pgcr_back #(
        .GLYPH_WIDTH (GLYPH_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_desc     (head_desc),
        .i_top_page (r_top_page),
        .o_pop      (q_pop),
        .o_out      (o_out)
    );

`ifndef ASSERT_OFF
    // The front end must never offer an entry the queue cannot hold.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    // Only the percent sign carries the end-of-readout flag.
    a_last_is_percent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_column) |->
            (o_out.glyph_slot == pgcr_pkg::SLOT_PERCENT))
        else $error("last column flagged outside the percent sign");

    // An entry is retired only while the queue holds one.
    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue read while empty");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the percent glyph column renderer top level.
// Needs pgcr_pkg, pgcr_if and the block's RTL; it predicts every column
// from its own font table and digit split, and compares each result in order.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Width of every glyph as built here; columns past the font are never sent.
    localparam int RENDER_WIDTH = 7;
    localparam int FONT_COLS    = 7;
    localparam int GLYPH_COLS   = (RENDER_WIDTH > FONT_COLS) ? FONT_COLS : RENDER_WIDTH;
    localparam int GLYPH_PCT    = 10;
    localparam int MAX_REPORTS  = 10;

    // One expected display column, field for field as the block sends it.
    typedef struct {
        logic [pgcr_pkg::SLOT_W-1:0]   slot;
        logic [pgcr_pkg::COLUMN_W-1:0] column;
        logic [pgcr_pkg::PAGE_W-1:0]   page;
        logic [pgcr_pkg::BYTES_W-1:0]  bytes;
        logic                          last;
    } t_column;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pgcr_in_if  in_bus ();
    pgcr_out_if out_bus ();

    percent_glyph_column_renderer_top #(
        .GLYPH_WIDTH (RENDER_WIDTH)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus.sink),
        .o_out   (out_bus.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Columns still owed by the block, oldest first.
    t_column     pending_columns[$];
    // The testbench's own copy of the top_page register.
    logic [2:0]  shadow_page;
    // Random idling on both channels; switched off for the closing stretch.
    bit          idle_on;
    int unsigned error_count;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A hang anywhere ends the run. The slowest correct run, every column
    // waiting out the longest stall, stays under a third of this.
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Font column c of glyph g, digits 0 to 9 and the percent sign at 10.
    // Each row lists the columns from left to right.
    function automatic logic [7:0] font_byte(input int g, input int c);
        logic [55:0] row;
        case (g)
            0:         row = 56'h00_7F_41_41_41_7F_00;
            1:         row = 56'h00_02_41_7F_40_00_00;
            2:         row = 56'h00_79_49_49_49_4F_00;
            3:         row = 56'h00_49_49_49_49_7F_00;
            4:         row = 56'h00_0F_08_08_08_7F_00;
            5:         row = 56'h00_4F_49_49_49_79_00;
            6:         row = 56'h00_7F_49_49_49_79_00;
            7:         row = 56'h00_01_61_11_0D_03_00;
            8:         row = 56'h00_7F_49_49_49_7F_00;
            9:         row = 56'h00_4F_49_49_49_7F_00;
            GLYPH_PCT: row = 56'h43_23_10_08_04_62_61;
            default:   row = '0;
        endcase
        return row[55-8*c -: 8];
    endfunction

    // Vertical scaling by three: source bit b lights result bits 3b to 3b+2.
    function automatic logic [pgcr_pkg::BYTES_W-1:0] stretch_column(input logic [7:0] src);
        logic [pgcr_pkg::BYTES_W-1:0] acc;
        acc = '0;
        for (int b = 0; b < 8; b++) begin
            if (src[b]) begin
                acc = acc | (24'h7 << (3 * b));
            end
        end
        return acc;
    endfunction

    // Leftmost display column of each slot.
    function automatic int column_base(input logic [pgcr_pkg::SLOT_W-1:0] slot);
        int base;
        case (slot)
            pgcr_pkg::SLOT_HUNDREDS: base = 23;
            pgcr_pkg::SLOT_TENS:     base = 44;
            pgcr_pkg::SLOT_UNITS:    base = 65;
            pgcr_pkg::SLOT_PERCENT:  base = 90;
            default:                 base = 0;
        endcase
        return base;
    endfunction

    // Works out every column that one value produces and queues them. Leading
    // zeros are dropped, so a value below 10 starts at the units slot and a
    // value below 100 at the tens slot; the percent sign always closes the row.
    task automatic queue_readout(input logic [pgcr_pkg::PERCENT_W-1:0] value);
        int          digit[3];
        int          first;
        int          g;
        logic [1:0]  slot;
        t_column     col;
        digit[0] = int'(value) / 100;
        digit[1] = (int'(value) / 10) % 10;
        digit[2] = int'(value) % 10;
        if (digit[0] == 0 && digit[1] == 0) begin
            first = 2;
        end else if (digit[0] == 0) begin
            first = 1;
        end else begin
            first = 0;
        end
        for (int s = first; s < 4; s++) begin
            slot = 2'(s);
            g    = (slot == pgcr_pkg::SLOT_PERCENT) ? GLYPH_PCT : digit[s];
            for (int c = 0; c < GLYPH_COLS; c++) begin
                col.slot   = slot;
                col.column = 7'(column_base(slot) + 3 * c);
                // Pages 6 and 7 pass through unchanged.
                col.page   = shadow_page;
                col.bytes  = stretch_column(font_byte(g, c));
                col.last   = (slot == pgcr_pkg::SLOT_PERCENT) && (c == GLYPH_COLS - 1);
                pending_columns.push_back(col);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Offers one value and returns at the clock edge that accepts the request.
    // valid is left high so that a following request can go straight out;
    // an optional gap lowers it first.
    task automatic send_percent(input logic [pgcr_pkg::PERCENT_W-1:0] value);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.percent <= value;
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        queue_readout(value);
    endtask

    // Lowers valid at the step of the last acceptance, then waits until every
    // queued column has been delivered, which leaves the block idle.
    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        while (pending_columns.size() != 0) @(posedge clk);
    endtask

    // Setup and access cycles on the register port; the register takes the
    // value at the access edge. The upper data bits carry noise on purpose.
    task automatic program_page(input logic [2:0] page);
        logic [31:0] data;
        wait_drained();
        data = {$urandom()} & 32'hFFFF_FFF8;
        data = data | {29'd0, page};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * int'(pgcr_pkg::REG_TOP_PAGE));
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_page = data[2:0];
    endtask

    // Spread of values: a fifth below 10, a fifth below 100, the rest anywhere.
    function automatic logic [pgcr_pkg::PERCENT_W-1:0] pick_percent();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            return 8'($urandom_range(0, 9));
        end else if (sel < 4) begin
            return 8'($urandom_range(10, 99));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stall bursts on ready, then the in-order check.
    // ------------------------------------------------------------------

    int stall_left;

    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_bus.ready <= (stall_left == 0);
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 11);
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : check_columns
        t_column want;
        if (rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_columns.size() == 0) begin
                flag_error($sformatf("exp none, got slot=%0d col=%0d",
                                     out_bus.glyph_slot, out_bus.display_column));
            end else begin
                want = pending_columns.pop_front();
                if (out_bus.glyph_slot !== want.slot
                        || out_bus.display_column !== want.column
                        || out_bus.start_page !== want.page
                        || out_bus.page_bytes !== want.bytes
                        || out_bus.last_column !== want.last) begin
                    flag_error($sformatf(
                        {"exp slot=%0d col=%0d page=%0d bytes=%06h last=%0b, ",
                         "got slot=%0d col=%0d page=%0d bytes=%06h last=%0b"},
                        want.slot, want.column, want.page, want.bytes, want.last,
                        out_bus.glyph_slot, out_bus.display_column, out_bus.start_page,
                        out_bus.page_bytes, out_bus.last_column));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Readout lengths and digit extremes at the page left by reset: zero, the
    // one- to two-digit and two- to three-digit boundaries, the largest value
    // and hundreds digits of 1 and 2, with every digit seen in several slots.
    task automatic test_value_extremes();
        logic [pgcr_pkg::PERCENT_W-1:0] values[$];
        values = '{8'd0, 8'd9, 8'd10, 8'd99, 8'd100, 8'd255, 8'd123, 8'd45,
                   8'd67, 8'd8, 8'd189, 8'd250, 8'd204, 8'd5, 8'd36, 8'd71,
                   8'd178, 8'd1};
        foreach (values[i]) begin
            send_percent(values[i]);
        end
    endtask

    // Lowest and highest in-range pages, then the two out-of-range pages,
    // which must be copied to start_page as written.
    task automatic test_page_extremes();
        logic [2:0] pages[$];
        pages = '{3'd0, 3'd5, 3'd6, 3'd7};
        foreach (pages[i]) begin
            program_page(pages[i]);
            send_percent(8'd7);
            send_percent(8'd128);
        end
    endtask

    // Random values in phases, each at a fresh random page. Halfway through the
    // third phase the sender is held back until the block has emptied, and the
    // final phase runs with no idling on either side.
    task automatic test_random_values();
        for (int phase = 0; phase < 6; phase++) begin
            program_page(3'($urandom_range(0, 7)));
            idle_on = (phase < 5);
            for (int n = 0; n < 70; n++) begin
                if (phase == 2 && n == 35) begin
                    wait_drained();
                end
                send_percent(pick_percent());
            end
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_bus.valid   = 1'b0;
        in_bus.percent = '0;
        out_bus.ready  = 1'b0;
        stall_left     = 0;
        error_count    = 0;
        idle_on        = 1'b1;
        shadow_page    = 3'd3;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_value_extremes();
        test_page_extremes();
        test_random_values();

        // Let the last columns out, then wait for any stray result.
        wait_drained();
        repeat (10) @(posedge clk);

        if (error_count == 0 && pending_columns.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pgcr_pkg.sv
hdl/pgcr_if.sv
hdl/pgcr_front.sv
hdl/pgcr_queue.sv
hdl/pgcr_back.sv
hdl/percent_glyph_column_renderer_top.sv
sim/testbench.sv
